### hdl/rect_region_allocator_top_assert.svh
// Assertion macros for the allocator datapath.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef RECT_REGION_ALLOCATOR_TOP_ASSERT_SVH
`define RECT_REGION_ALLOCATOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the trigger.
`define RRA_CHECK_IMP(lbl, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error("allocator check failed");

// The consequent must hold in the cycle after the trigger.
`define RRA_CHECK_NXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("allocator check failed");

`endif

### hdl/rra_pkg.sv
package rra_pkg;

  // Request kinds.
  localparam logic [1:0] KIND_PLACE   = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_RESIZE  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic free_clr;
    logic free_inc;
    logic tslot_free;
    logic srch_init;
    logic lim_set;
    logic scan_clr;
    logic scan_rd;
    logic box_rd;
    logic scan_inc;
    logic jump;
    logic box_wr;
    logic order_app;
    logic set_valid;
    logic clr_valid;
    logic ul_clr;
    logic ul_rd;
    logic ul_step;
    logic ul_done;
    logic res_set;
    logic res_ok;
    logic res_slot;
    logic res_pos;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] kind;
    logic       free_hit;
    logic       free_last;
    logic       size_bad;
    logic       slot_ok;
    logic       scan_end;
    logic       hit;
    logic       both_of;
    logic       step_over;
    logic       out_free;
  } sts_t;

endpackage

### hdl/rra_ctrl.sv
module rra_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  rra_pkg::sts_t sts,
  output rra_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_FREE    = 4'd2;
  localparam logic [3:0] S_LIM     = 4'd3;
  localparam logic [3:0] S_LOOP    = 4'd4;
  localparam logic [3:0] S_SC_RD   = 4'd5;
  localparam logic [3:0] S_SC_WAIT = 4'd6;
  localparam logic [3:0] S_SC_CMP  = 4'd7;
  localparam logic [3:0] S_JUMP    = 4'd8;
  localparam logic [3:0] S_UL_RD   = 4'd9;
  localparam logic [3:0] S_UL_WR   = 4'd10;
  localparam logic [3:0] S_FIN     = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  // A new beat is taken only between requests.
  assign in_stall = (state != S_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencing of each request.
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.kind)
          rra_pkg::KIND_PLACE: begin
            cmd.free_clr = 1'b1;
            state_next   = S_FREE;
          end
          rra_pkg::KIND_RELEASE: begin
            if (sts.slot_ok) begin
              cmd.ul_clr = 1'b1;
              state_next = S_UL_RD;
            end else begin
              cmd.res_set  = 1'b1;
              cmd.res_slot = 1'b1;
              state_next   = S_FIN;
            end
          end
          rra_pkg::KIND_RESIZE: begin
            if (sts.slot_ok) begin
              cmd.srch_init = 1'b1;
              state_next    = S_LIM;
            end else begin
              cmd.res_set  = 1'b1;
              cmd.res_slot = 1'b1;
              state_next   = S_FIN;
            end
          end
          default: begin
            cmd.res_set = 1'b1;
            state_next  = S_FIN;
          end
        endcase
      end
      S_FREE: begin
        priority if (sts.free_hit) begin
          cmd.tslot_free = 1'b1;
          cmd.srch_init  = 1'b1;
          state_next     = S_LIM;
        end else if (sts.free_last) begin
          cmd.res_set = 1'b1;
          state_next  = S_FIN;
        end else begin
          cmd.free_inc = 1'b1;
        end
      end
      S_LIM: begin
        cmd.lim_set = 1'b1;
        if (sts.size_bad) begin
          if (sts.kind == rra_pkg::KIND_RESIZE) begin
            cmd.ul_clr = 1'b1;
            state_next = S_UL_RD;
          end else begin
            cmd.res_set = 1'b1;
            state_next  = S_FIN;
          end
        end else begin
          state_next = S_LOOP;
        end
      end
      S_LOOP: begin
        if (sts.step_over) begin
          if (sts.kind == rra_pkg::KIND_RESIZE) begin
            cmd.ul_clr = 1'b1;
            state_next = S_UL_RD;
          end else begin
            cmd.res_set = 1'b1;
            state_next  = S_FIN;
          end
        end else begin
          cmd.scan_clr = 1'b1;
          state_next   = S_SC_RD;
        end
      end
      S_SC_RD: begin
        if (sts.scan_end) begin
          // No stored box overlaps: the spot is taken.
          cmd.box_wr   = 1'b1;
          cmd.res_set  = 1'b1;
          cmd.res_ok   = 1'b1;
          cmd.res_slot = 1'b1;
          cmd.res_pos  = 1'b1;
          if (sts.kind == rra_pkg::KIND_PLACE) begin
            cmd.set_valid = 1'b1;
            cmd.order_app = 1'b1;
          end
          state_next = S_FIN;
        end else begin
          cmd.scan_rd = 1'b1;
          state_next  = S_SC_WAIT;
        end
      end
      S_SC_WAIT: begin
        cmd.box_rd = 1'b1;
        state_next = S_SC_CMP;
      end
      S_SC_CMP: begin
        if (sts.hit) begin
          state_next = S_JUMP;
        end else begin
          cmd.scan_inc = 1'b1;
          state_next   = S_SC_RD;
        end
      end
      S_JUMP: begin
        if (sts.both_of) begin
          if (sts.kind == rra_pkg::KIND_RESIZE) begin
            cmd.ul_clr = 1'b1;
            state_next = S_UL_RD;
          end else begin
            cmd.res_set = 1'b1;
            state_next  = S_FIN;
          end
        end else begin
          cmd.jump   = 1'b1;
          state_next = S_LOOP;
        end
      end
      S_UL_RD: begin
        if (sts.scan_end) begin
          cmd.ul_done   = 1'b1;
          cmd.clr_valid = 1'b1;
          cmd.res_set   = 1'b1;
          cmd.res_ok    = (sts.kind == rra_pkg::KIND_RELEASE);
          cmd.res_slot  = 1'b1;
          state_next    = S_FIN;
        end else begin
          cmd.ul_rd  = 1'b1;
          state_next = S_UL_WR;
        end
      end
      S_UL_WR: begin
        cmd.ul_step = 1'b1;
        state_next  = S_UL_RD;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### hdl/rra_datapath.sv
`include "rect_region_allocator_top_assert.svh"

module rra_datapath #(
  parameter int REGION_SIZE = 2048,
  parameter int MAX_SLOTS   = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  rra_pkg::cmd_t cmd,
  output rra_pkg::sts_t sts,
  input  logic [1:0]    kind,
  input  logic          layer_select,
  input  logic [11:0]   box_width,
  input  logic [11:0]   box_height,
  input  logic [7:0]    slot_in,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          ok,
  output logic [7:0]    slot_out,
  output logic [10:0]   place_x,
  output logic [10:0]   place_y
);

  localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int AW = SW + 1;
  localparam int CW = $clog2(REGION_SIZE) + 1;
  localparam int EW = CW + 1;
  localparam int QW = 2 * SW + 2;
  localparam int LW = 2 * SW + 4;

  // Request registers.
  logic [1:0]  req_kind;
  logic        req_layer;
  logic [11:0] req_w;
  logic [11:0] req_h;
  logic [7:0]  req_slot;
  logic [SW-1:0] tslot;

  // Counters and per-layer list lengths.
  logic [SW:0] idx;
  logic [SW:0] wr_idx;
  logic [SW:0] scan_count [2];
  logic [SW:0] cur_count;

  // Stores: insertion-order list, box table and slot occupancy.
  logic [SW-1:0]   order_mem [2**AW];
  logic [SW-1:0]   order_q;
  logic [4*CW-1:0] box_mem [2**AW];
  logic [4*CW-1:0] box_q;
  logic [2**AW-1:0] valid_bits;

  // Search state.
  logic [CW-1:0] cur_x;
  logic [CW-1:0] cur_y;
  logic          hint_x;
  logic          hint_y;
  logic [LW-1:0] step;
  logic [LW-1:0] limit;
  logic [QW-1:0] sq;

  // Staged and delivered results.
  logic          res_ok;
  logic [SW-1:0] res_slot;
  logic [CW-1:0] res_x;
  logic [CW-1:0] res_y;

  logic [CW-1:0] w_c;
  logic [CW-1:0] h_c;
  logic [CW-1:0] bx;
  logic [CW-1:0] by;
  logic [CW-1:0] bw;
  logic [CW-1:0] bh;
  logic          hit_raw;
  logic          axis_x;
  logic [EW-1:0] jx;
  logic [EW-1:0] jy;
  logic          of_x;
  logic          of_y;
  logic          keep;
  logic [SW:0]   n1;

  assign cur_count = scan_count[req_layer];
  assign w_c = CW'(req_w);
  assign h_c = CW'(req_h);
  assign {bx, by, bw, bh} = box_q;
  assign keep = (order_q != tslot);
  assign n1 = cur_count + (SW+1)'(1);

  // Overlap of the candidate with the box just read, as inclusive ranges.
  assign hit_raw = (EW'(bx) <= EW'(cur_x) + EW'(w_c) - EW'(1)) &&
                   (EW'(cur_x) <= EW'(bx) + EW'(bw) - EW'(1)) &&
                   (EW'(by) <= EW'(cur_y) + EW'(h_c) - EW'(1)) &&
                   (EW'(cur_y) <= EW'(by) + EW'(bh) - EW'(1));

  // Jump past the hit box on the chosen axis, then test both overflows.
  assign axis_x = hint_x || ((w_c < h_c) && !hint_y);
  assign jx = axis_x ? EW'(bx) + EW'(bw) : EW'(cur_x);
  assign jy = axis_x ? EW'(cur_y) : EW'(by) + EW'(bh);
  assign of_x = (jx + EW'(w_c)) > EW'(REGION_SIZE);
  assign of_y = (jy + EW'(h_c)) > EW'(REGION_SIZE);

  // Status towards the controller.
  always_comb begin
    sts.kind      = req_kind;
    sts.free_hit  = !valid_bits[{req_layer, idx[SW-1:0]}];
    sts.free_last = (idx == (SW+1)'(MAX_SLOTS - 1));
    sts.size_bad  = (req_w == 12'd0) || (req_h == 12'd0) ||
                    (32'(req_w) > 32'(REGION_SIZE)) || (32'(req_h) > 32'(REGION_SIZE));
    sts.slot_ok   = (32'(req_slot) < 32'(MAX_SLOTS)) &&
                    valid_bits[{req_layer, SW'(req_slot)}];
    sts.scan_end  = (idx >= cur_count);
    sts.hit       = hit_raw && !((req_kind == rra_pkg::KIND_RESIZE) && (order_q == tslot));
    sts.both_of   = of_x && of_y;
    sts.step_over = (step > limit);
    sts.out_free  = !out_valid || !out_stall;
  end

  // Request capture and target slot.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_kind  <= kind;
      req_layer <= layer_select;
      req_w     <= box_width;
      req_h     <= box_height;
      req_slot  <= slot_in;
      tslot     <= SW'(slot_in);
    end else if (cmd.tslot_free) begin
      tslot <= idx[SW-1:0];
    end
  end

  // Shared index and compaction write index.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= '0;
      wr_idx <= '0;
    end else begin
      if (cmd.free_clr || cmd.scan_clr || cmd.ul_clr) begin
        idx <= '0;
      end else if (cmd.free_inc || cmd.scan_inc || cmd.ul_step) begin
        idx <= idx + (SW+1)'(1);
      end
      if (cmd.ul_clr) begin
        wr_idx <= '0;
      end else if (cmd.ul_step && keep) begin
        wr_idx <= wr_idx + (SW+1)'(1);
      end
    end
  end

  // List lengths per layer.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_count[0] <= '0;
      scan_count[1] <= '0;
    end else if (cmd.order_app && (cur_count < (SW+1)'(MAX_SLOTS))) begin
      scan_count[req_layer] <= cur_count + (SW+1)'(1);
    end else if (cmd.ul_done) begin
      scan_count[req_layer] <= wr_idx;
    end
  end

  // Insertion-order list: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (cmd.order_app && (cur_count < (SW+1)'(MAX_SLOTS))) begin
      order_mem[{req_layer, cur_count[SW-1:0]}] <= tslot;
    end else if (cmd.ul_step && keep) begin
      order_mem[{req_layer, wr_idx[SW-1:0]}] <= order_q;
    end
    if (cmd.scan_rd || cmd.ul_rd) begin
      order_q <= order_mem[{req_layer, idx[SW-1:0]}];
    end
  end

  // Box table.
  always_ff @(posedge clk) begin
    if (cmd.box_wr) begin
      box_mem[{req_layer, tslot}] <= {cur_x, cur_y, w_c, h_c};
    end
    if (cmd.box_rd) begin
      box_q <= box_mem[{req_layer, order_q}];
    end
  end

  // Slot occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (cmd.set_valid) begin
      valid_bits[{req_layer, tslot}] <= 1'b1;
    end else if (cmd.clr_valid) begin
      valid_bits[{req_layer, tslot}] <= 1'b0;
    end
  end

  // Search position, hints, step count and step limit.
  always_ff @(posedge clk) begin
    if (cmd.srch_init) begin
      cur_x  <= '0;
      cur_y  <= '0;
      hint_x <= 1'b0;
      hint_y <= 1'b0;
      step   <= '0;
      sq     <= QW'(n1) * QW'(n1);
    end else if (cmd.jump) begin
      cur_x  <= of_x ? '0 : CW'(jx);
      cur_y  <= of_y ? '0 : CW'(jy);
      hint_x <= of_y || (!axis_x && hint_x);
      hint_y <= of_x || (axis_x && hint_y);
      step   <= step + LW'(1);
    end
    if (cmd.lim_set) begin
      limit <= LW'({sq, 1'b0}) + LW'(sq);
    end
  end

  // Staged result.
  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_ok   <= cmd.res_ok;
      res_slot <= cmd.res_slot ? tslot : '0;
      res_x    <= cmd.res_pos ? cur_x : '0;
      res_y    <= cmd.res_pos ? cur_y : '0;
    end
  end

  // Output register; the beat holds while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      ok       <= res_ok;
      slot_out <= 8'(res_slot);
      place_x  <= 11'(res_x);
      place_y  <= 11'(res_y);
    end
  end

  `RRA_CHECK_IMP(a_app_room, cmd.order_app, cur_count < (SW+1)'(MAX_SLOTS))
  `RRA_CHECK_IMP(a_no_overwrite, cmd.out_load, !out_valid || !out_stall)
  `RRA_CHECK_IMP(a_compact_order, cmd.ul_step, wr_idx <= idx)
  `RRA_CHECK_NXT(a_slot_freed, cmd.clr_valid, !valid_bits[{req_layer, tslot}])

endmodule

### hdl/rect_region_allocator_top.sv
// Rectangle allocator over a square region, with a normal and a virtual layer
// of MAX_SLOTS slots each. One request is worked at a time; in_stall is high
// from acceptance until the result is moved to the output register. Stored
// boxes are visited one at a time through the list and box memories, and a
// placement repeats this collision test pass after each jump. A new box first
// scans up to MAX_SLOTS slots for a free one, and a release compacts the
// insertion-order list. The result beat waits in its own register, so the
// next request can start while it is still stalled.
module rect_region_allocator_top #(
  parameter int REGION_SIZE = 2048,
  parameter int MAX_SLOTS   = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic        layer_select,
  input  logic [11:0] box_width,
  input  logic [11:0] box_height,
  input  logic [7:0]  slot_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        ok,
  output logic [7:0]  slot_out,
  output logic [10:0] place_x,
  output logic [10:0] place_y
);

  rra_pkg::cmd_t cmd;
  rra_pkg::sts_t sts;

  // Controller.
  rra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath with the stores.
  rra_datapath #(
    .REGION_SIZE (REGION_SIZE),
    .MAX_SLOTS   (MAX_SLOTS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .kind         (kind),
    .layer_select (layer_select),
    .box_width    (box_width),
    .box_height   (box_height),
    .slot_in      (slot_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .ok           (ok),
    .slot_out     (slot_out),
    .place_x      (place_x),
    .place_y      (place_y)
  );

endmodule
